[hdl/sha0_hash_engine_core_macros.svh]
// assertion macros for the sha-0 hash engine
`ifndef SHA0_HASH_ENGINE_CORE_MACROS_SVH
`define SHA0_HASH_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SHA0_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha0 assertion failed");
`define SHA0_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha0 assertion failed");
`else
`define SHA0_ASSERT_SAME(lbl, ante, cons)
`define SHA0_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/sha0_pkg.sv]
// types and constants of the sha-0 hash engine
package sha0_pkg;

    typedef logic [31:0] word_t;
    typedef logic [2:0]  bcnt_t;
    typedef logic [2:0]  widx_t;

    localparam word_t SHA0_K0 = 32'h5a827999;
    localparam word_t SHA0_K1 = 32'h6ed9eba1;
    localparam word_t SHA0_K2 = 32'h8f1bbcdc;
    localparam word_t SHA0_K3 = 32'hca62c1d6;

    localparam word_t SHA0_IV [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam int         TOTAL_W    = 61;
    localparam logic [6:0] LAST_ROUND = 7'd79;

endpackage

[hdl/sha0_msg_if.sv]
// message word channel
interface sha0_msg_if
    import sha0_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t data_word;
    bcnt_t byte_count;
    logic  last_word;

    modport source (output valid, output data_word, output byte_count, output last_word,
                    input ready);
    modport sink (input valid, input data_word, input byte_count, input last_word,
                  output ready);
endinterface

[hdl/sha0_dgst_if.sv]
// digest word channel
interface sha0_dgst_if
    import sha0_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t digest_word;
    widx_t word_index;
    logic  digest_last;

    modport source (output valid, output digest_word, output word_index, output digest_last,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input digest_last,
                  output ready);
endinterface

[hdl/sha0_hash_engine_core.sv]
// sha-0 hash engine top level
// non-final item: an aligned four-byte word is pushed whole, else one byte at a time
// a full 64-byte block is compressed: 80 rounds on the one round adder, then the chain add
// final item: pad and length words, one or two compressions, then five digest items,
// one per cycle while dgst.ready is high; not ready from accept until the digest is taken
// reset is asynchronous: chain to the initial values, counters cleared, schedule not reset
`include "sha0_hash_engine_core_macros.svh"

module sha0_hash_engine_core
    import sha0_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sha0_msg_if.sink    req,
    sha0_dgst_if.source dgst
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BYTE  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_ZERO  = 3'd5;
    localparam logic [2:0] S_LEN   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic [1:0] PH_MSG   = 2'd0;
    localparam logic [1:0] PH_PAD1  = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         phase_reg, phase_next;
    word_t              chain_reg [5];
    word_t              chain_next [5];
    word_t              vars_reg [5];
    word_t              vars_next [5];
    word_t              sched_reg [16];
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [6:0]         rnd_reg, rnd_next;
    word_t              partial_reg, partial_next;
    word_t              data_reg, data_next;
    bcnt_t              left_reg, left_next;
    logic               last_reg, last_next;
    logic [4:0]         fill_reg, fill_next;
    widx_t              oidx_reg, oidx_next;

    logic               push;
    word_t              push_word;
    bcnt_t              cnt_c;
    bcnt_t              left_after;
    logic [1:0]         lane;
    logic [4:0]         lane_sh;
    word_t              merged;
    word_t              pad_word;
    logic [63:0]        bit_len;
    word_t              f_w, k_w, t_w, w_exp;
    logic               blk_full;
    logic               go_comp;

    assign req.ready        = (state_reg == S_IDLE);
    assign dgst.valid       = (state_reg == S_OUT);
    assign dgst.digest_word = chain_reg[0];
    assign dgst.word_index  = oidx_reg;
    assign dgst.digest_last = (oidx_reg == 3'd4);

    assign cnt_c    = (req.byte_count > 3'd4) ? 3'd4 : req.byte_count;
    assign lane     = total_reg[1:0];
    assign lane_sh  = {~lane, 3'b000};
    assign merged   = partial_reg | ({24'd0, data_reg[31:24]} << lane_sh);
    assign pad_word = partial_reg | ({24'd0, PAD_BYTE} << lane_sh);
    assign bit_len  = {total_reg, 3'b000};
    assign w_exp    = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f_w = vars_reg[3] ^ (vars_reg[1] & (vars_reg[2] ^ vars_reg[3]));
            k_w = SHA0_K0;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_w = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k_w = SHA0_K1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_w = (vars_reg[1] & vars_reg[2]) | (vars_reg[3] & (vars_reg[1] | vars_reg[2]));
            k_w = SHA0_K2;
        end
        else
        begin
            f_w = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
            k_w = SHA0_K3;
        end
        t_w = vars_reg[4] + {vars_reg[0][26:0], vars_reg[0][31:27]} + f_w + k_w
            + sched_reg[0];
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        chain_next   = chain_reg;
        vars_next    = vars_reg;
        total_next   = total_reg;
        rnd_next     = rnd_reg;
        partial_next = partial_reg;
        data_next    = data_reg;
        left_next    = left_reg;
        last_next    = last_reg;
        fill_next    = fill_reg;
        oidx_next    = oidx_reg;
        push         = 1'b0;
        push_word    = '0;
        left_after   = left_reg;
        blk_full     = 1'b0;
        go_comp      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    data_next = req.data_word;
                    left_next = cnt_c;
                    last_next = req.last_word;
                    if (cnt_c != 3'd0)
                        state_next = S_BYTE;
                    else if (req.last_word)
                        state_next = S_PAD;
                end
            end
            S_BYTE:
            begin
                if ((lane == 2'd0) && (left_reg == 3'd4))
                begin
                    push       = 1'b1;
                    push_word  = data_reg;
                    total_next = total_reg + TOTAL_W'(4);
                    left_after = 3'd0;
                    blk_full   = (total_reg[5:2] == 4'd15);
                end
                else
                begin
                    data_next  = {data_reg[23:0], 8'd0};
                    total_next = total_reg + TOTAL_W'(1);
                    left_after = left_reg - 3'd1;
                    if (lane == 2'd3)
                    begin
                        push         = 1'b1;
                        push_word    = merged;
                        partial_next = '0;
                        blk_full     = (total_reg[5:2] == 4'd15);
                    end
                    else
                        partial_next = merged;
                end
                left_next = left_after;
                if (blk_full)
                begin
                    go_comp    = 1'b1;
                    phase_next = PH_MSG;
                end
                else if (left_after != 3'd0)
                    state_next = S_BYTE;
                else if (last_reg)
                    state_next = S_PAD;
                else
                    state_next = S_IDLE;
            end
            S_ROUND:
            begin
                push        = 1'b1;
                push_word   = w_exp;
                vars_next[4] = vars_reg[3];
                vars_next[3] = vars_reg[2];
                vars_next[2] = {vars_reg[1][1:0], vars_reg[1][31:2]};
                vars_next[1] = vars_reg[0];
                vars_next[0] = t_w;
                rnd_next     = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    rnd_next   = '0;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                for (int i = 0; i < 5; i++)
                    chain_next[i] = chain_reg[i] + vars_reg[i];
                unique case (phase_reg)
                    PH_PAD1:  state_next = S_ZERO;
                    PH_FINAL: state_next = S_OUT;
                    default:
                    begin
                        if (left_reg != 3'd0)
                            state_next = S_BYTE;
                        else if (last_reg)
                            state_next = S_PAD;
                        else
                            state_next = S_IDLE;
                    end
                endcase
            end
            S_PAD:
            begin
                push         = 1'b1;
                push_word    = pad_word;
                partial_next = '0;
                fill_next    = {1'b0, total_reg[5:2]} + 5'd1;
                state_next   = S_ZERO;
            end
            S_ZERO:
            begin
                if (fill_reg == 5'd16)
                begin
                    fill_next  = '0;
                    phase_next = PH_PAD1;
                    go_comp    = 1'b1;
                end
                else if (fill_reg == 5'd14)
                    state_next = S_LEN;
                else
                begin
                    push      = 1'b1;
                    push_word = '0;
                    fill_next = fill_reg + 5'd1;
                end
            end
            S_LEN:
            begin
                push = 1'b1;
                if (fill_reg == 5'd14)
                begin
                    push_word = bit_len[63:32];
                    fill_next = 5'd15;
                end
                else
                begin
                    push_word  = bit_len[31:0];
                    fill_next  = '0;
                    phase_next = PH_FINAL;
                    go_comp    = 1'b1;
                end
            end
            S_OUT:
            begin
                if (dgst.ready)
                begin
                    for (int i = 0; i < 4; i++)
                        chain_next[i] = chain_reg[i + 1];
                    chain_next[4] = chain_reg[0];
                    oidx_next     = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd4)
                    begin
                        chain_next   = SHA0_IV;
                        total_next   = '0;
                        partial_next = '0;
                        phase_next   = PH_MSG;
                        oidx_next    = '0;
                        last_next    = 1'b0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (go_comp)
        begin
            vars_next  = chain_reg;
            rnd_next   = '0;
            state_next = S_ROUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_MSG;
            chain_reg   <= SHA0_IV;
            vars_reg    <= '{default: '0};
            total_reg   <= '0;
            rnd_reg     <= '0;
            partial_reg <= '0;
            left_reg    <= '0;
            last_reg    <= 1'b0;
            fill_reg    <= '0;
            oidx_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            chain_reg   <= chain_next;
            vars_reg    <= vars_next;
            total_reg   <= total_next;
            rnd_reg     <= rnd_next;
            partial_reg <= partial_next;
            left_reg    <= left_next;
            last_reg    <= last_next;
            fill_reg    <= fill_next;
            oidx_reg    <= oidx_next;
        end
    end

    // message window, shifted one word per push
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (push)
        begin
            for (int i = 0; i < 15; i++)
                sched_reg[i] <= sched_reg[i + 1];
            sched_reg[15] <= push_word;
        end
    end

    `SHA0_ASSERT_SAME(a_out_blocks_in, dgst.valid, !req.ready)
    `SHA0_ASSERT_NEXT(a_round_end, (state_reg == S_ROUND) && (rnd_reg == LAST_ROUND), state_reg == S_ADD)
    `SHA0_ASSERT_NEXT(a_reinit, dgst.valid && dgst.ready && dgst.digest_last, (state_reg == S_IDLE) && (total_reg == '0))
    `SHA0_ASSERT_SAME(a_fill_range, state_reg == S_ZERO, fill_reg <= 5'd16)

endmodule

[dv/sha0_hash_engine_core_checker.sv]
// checker for the sha-0 hash engine: watches both channels, predicts digests and compares them
module sha0_hash_engine_core_checker
    import sha0_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    sha0_msg_if   req,
    sha0_dgst_if  dgst,
    output int    fail_count,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        word_t value;
        widx_t index;
        logic  final_flag;
    } digest_item_t;

    word_t              chain_v [5];
    word_t              sched_w [16];
    logic [TOTAL_W-1:0] bytes_taken;
    word_t              gather_w;
    digest_item_t       digest_q [$];

    function automatic void run_rounds();
        word_t a, b, c, d, e, w, f, k, t;
        a = chain_v[0];
        b = chain_v[1];
        c = chain_v[2];
        d = chain_v[3];
        e = chain_v[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
                w = sched_w[r];
            else
            begin
                w = sched_w[r % 16] ^ sched_w[(r - 14) % 16]
                  ^ sched_w[(r - 8) % 16] ^ sched_w[(r - 3) % 16];
                sched_w[r % 16] = w;
            end
            if (r < 20)
            begin
                f = d ^ (b & (c ^ d));
                k = SHA0_K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = SHA0_K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (d & (b | c));
                k = SHA0_K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = SHA0_K3;
            end
            t = e + {a[26:0], a[31:27]} + f + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_v[0] += a;
        chain_v[1] += b;
        chain_v[2] += c;
        chain_v[3] += d;
        chain_v[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] value);
        int pos;
        int lane;
        pos  = int'(bytes_taken[5:0]);
        lane = pos % 4;
        gather_w = gather_w | (word_t'(value) << (24 - 8 * lane));
        bytes_taken = bytes_taken + 1'b1;
        if (lane == 3)
        begin
            sched_w[pos / 4] = gather_w;
            gather_w = '0;
            if (pos == 63)
                run_rounds();
        end
    endfunction

    function automatic void pad_and_finish();
        int          pos;
        int          wi;
        logic [63:0] bit_len;
        pos     = int'(bytes_taken[5:0]);
        wi      = pos / 4;
        bit_len = {bytes_taken, 3'b000};
        sched_w[wi] = gather_w | (word_t'(PAD_BYTE) << (24 - 8 * (pos % 4)));
        for (int i = wi + 1; i < 16; i++)
            sched_w[i] = '0;
        if (pos > 55)
        begin
            run_rounds();
            for (int i = 0; i < 16; i++)
                sched_w[i] = '0;
        end
        sched_w[14] = bit_len[63:32];
        sched_w[15] = bit_len[31:0];
        run_rounds();
    endfunction

    function automatic void predict_item(input word_t data, input bcnt_t count,
                                         input logic ends_msg);
        int           n;
        digest_item_t item;
        n = (count > 3'd4) ? 4 : int'(count);
        for (int i = 0; i < n; i++)
            absorb_byte(data[31 - 8 * i -: 8]);
        if (ends_msg)
        begin
            pad_and_finish();
            for (int i = 0; i < 5; i++)
            begin
                item.value      = chain_v[i];
                item.index      = widx_t'(i);
                item.final_flag = (i == 4);
                digest_q.push_back(item);
            end
            chain_v     = SHA0_IV;
            bytes_taken = '0;
            gather_w    = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_item_t seen;
        digest_item_t want;
        if (!rst_n)
        begin
            chain_v     = SHA0_IV;
            for (int i = 0; i < 16; i++)
                sched_w[i] = '0;
            bytes_taken = '0;
            gather_w    = '0;
            digest_q.delete();
            pending     = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                predict_item(req.data_word, req.byte_count, req.last_word);
            if (dgst.valid && dgst.ready)
            begin
                seen.value      = dgst.digest_word;
                seen.index      = dgst.word_index;
                seen.final_flag = dgst.digest_last;
                if (digest_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected digest item: actual %h/%0d/%b",
                             $time, seen.value, seen.index, seen.final_flag);
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        $display("%0t: digest mismatch: expected %h/%0d/%b, actual %h/%0d/%b",
                                 $time, want.value, want.index, want.final_flag,
                                 seen.value, seen.index, seen.final_flag);
                    end
                end
            end
            pending = digest_q.size();
        end
    end

endmodule

[dv/sha0_hash_engine_core_tb.sv]
// testbench top for the sha-0 hash engine: clock, reset, message stimulus and verdict
module sha0_hash_engine_core_tb
    import sha0_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    bit   rx_hold_req;
    int   items_sent;
    int   fail_count;
    int   pending;

    sha0_msg_if  req_ch();
    sha0_dgst_if dgst_ch();

    sha0_hash_engine_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .dgst  (dgst_ch)
    );

    sha0_hash_engine_core_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .dgst       (dgst_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // digest side: random back-pressure, with one long hold on request
    initial
    begin
        dgst_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                dgst_ch.ready <= 1'b0;
                repeat (1000) @(negedge clk);
            end
            dgst_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_word(input word_t data, input bcnt_t count, input logic ends_msg);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.data_word  <= data;
        req_ch.byte_count <= count;
        req_ch.last_word  <= ends_msg;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (count != 3'd0 || ends_msg)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_message();
        int  n;
        bit  noisy;
        n     = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
        noisy = ($urandom_range(99) < 15);
        for (int i = 0; i < n; i++)
            send_word($urandom, (noisy && $urandom_range(3) == 0) ?
                      bcnt_t'($urandom_range(0, 7)) : bcnt_t'(4), 1'b0);
        send_word($urandom, noisy ? bcnt_t'($urandom_range(0, 7)) :
                  bcnt_t'($urandom_range(0, 4)), 1'b1);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        tx_idle_pct        = 0;
        rx_idle_pct        = 0;
        rx_hold_req        = 1'b0;
        items_sent         = 0;
        req_ch.valid       = 1'b0;
        req_ch.data_word   = '0;
        req_ch.byte_count  = '0;
        req_ch.last_word   = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty message, "abc", full words of extreme data
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'h61626300, 3'd3, 1'b1);
        send_word(32'hffffffff, 3'd4, 1'b1);
        send_word(32'h00000000, 3'd7, 1'b1);
        // short words before the end stay byte-packed
        send_word(32'hab000000, 3'd1, 1'b0);
        send_word(32'hcdef0000, 3'd2, 1'b0);
        send_word(32'h12345678, 3'd4, 1'b1);
        // oversize byte counts
        send_word(32'hdeadbeef, 3'd5, 1'b0);
        send_word(32'hfeedf00d, 3'd6, 1'b1);
        // 56 bytes, padding spills into a second block
        for (int i = 0; i < 14; i++)
            send_word(32'hffffffff, 3'd4, i == 13);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            tx_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 52 : 0;
            rx_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 20 : 0;
            if (ph == 2)
                rx_hold_req = 1'b1;
            while (items_sent < 23 + 72 * (ph + 1))
                send_random_message();
            drain();
        end

        repeat (250) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
